/* sv/difference_constraint_solver_assert.svh */
// assertion macros for the difference constraint solver checker
// no dependencies
`ifndef DIFFERENCE_CONSTRAINT_SOLVER_ASSERT_SVH
`define DIFFERENCE_CONSTRAINT_SOLVER_ASSERT_SVH

// same-cycle implication
`define DCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dcs_pkg.sv */
// shared types, codes and constants for the difference constraint solver
// no dependencies
package dcs_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_EDGES_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int NODE_W  = 7;
    localparam int HOP_W   = 8;
    localparam int DIST_W  = 48;
    localparam int BOUND_W = 16;
    localparam int VALUE_W = 32;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_SOLVE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INFEAS    = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOTSOLVED = 2'd3;

    localparam logic signed [DIST_W-1:0] VAL_MIN = -(48'sd2147483648);
    localparam logic signed [DIST_W-1:0] VAL_MAX = 48'sd2147483647;

    typedef struct packed {
        logic [1:0]                func;
        logic [NODE_W-1:0]         first_node;
        logic [NODE_W-1:0]         second_node;
        logic signed [BOUND_W-1:0] bound;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] node_value;
    } t_result;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [HOP_W-1:0]  hops;
    } t_qent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDW,
        S_INIT,
        S_POP,
        S_POPW,
        S_CURW,
        S_EREAD,
        S_EWAIT,
        S_RELAX
    } t_state;

endpackage

/* sv/dcs_ram.sv */
// simple dual port synchronous ram with a registered read port
// no dependencies
module dcs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

/* sv/dcs_queue.sv */
// circular work queue of node and hop count held in a ram
// depends on dcs_pkg
module dcs_queue #(
    parameter int MAX_NODES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_push,
    input  dcs_pkg::t_qent i_push_data,
    input  logic          i_pop,
    output dcs_pkg::t_qent o_pop_data,
    output logic          o_empty,
    output logic          o_full
);
    import dcs_pkg::*;

    localparam int QA  = $clog2(MAX_NODES);
    localparam int QCW = $clog2(MAX_NODES + 1);

    t_qent             mem [MAX_NODES];
    logic [QA-1:0]     r_head, n_head;
    logic [QCW-1:0]    r_count, n_count;
    logic [QCW:0]      tail_sum;
    logic [QA-1:0]     tail;
    logic [QCW:0]      head_sum;

    always_comb begin
        tail_sum = (QCW+1)'(r_head) + (QCW+1)'(r_count);
        if (tail_sum >= (QCW+1)'(MAX_NODES)) begin
            tail_sum = tail_sum - (QCW+1)'(MAX_NODES);
        end
        tail = tail_sum[QA-1:0];
        head_sum = (QCW+1)'(r_head) + (QCW+1)'(1);
        if (head_sum >= (QCW+1)'(MAX_NODES)) begin
            head_sum = '0;
        end
        n_head  = r_head;
        n_count = r_count;
        if (i_clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_pop) begin
            n_head  = head_sum[QA-1:0];
            n_count = r_count - QCW'(1);
        end else if (i_push) begin
            n_count = r_count + QCW'(1);
        end
    end

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCW'(MAX_NODES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !i_clear) begin
            mem[tail] <= i_push_data;
        end
        if (i_pop) begin
            o_pop_data <= mem[r_head];
        end
    end

endmodule

/* sv/difference_constraint_solver.sv */
// top level of the difference constraint solver: command decode, solve sequencer
// depends on dcs_pkg, dcs_ram, dcs_queue
//
// usage
//   commands enter on i_cmd, taken at a clock edge with start high and busy low
//   every command gives one transaction on o_result, marked by o_valid for one cycle
//   add and clear: the result is registered and shown in the cycle after the command, busy stays low
//   read of a node in range after a good solve: the result comes from S_RDW after the
//     distance ram read; any other read answers in the cycle after the command
//   solve: queue based bellman-ford; init gives each node distance zero and queues it;
//     each pop of a node passes S_POP, S_POPW and S_CURW, then S_EREAD and S_EWAIT per
//     edge, S_RELAX per edge from it to a node in range; the ram reads set this pace
//   the solve ends at a pop that finds the queue empty (result in the next cycle) or at a
//     node whose hop count exceeds the clamped node count (result is registered from S_POPW)
//   i_cfg_we writes node_count while idle (ignored while busy) and marks the results as unsolved
//   reset empties the edge store and clears the solved state; node_count goes to 64
//   the receiver cannot stall: a result is shown once and is gone the next cycle
module difference_constraint_solver #(
    parameter int MAX_NODES   = dcs_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = dcs_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = dcs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dcs_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [dcs_pkg::NODE_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    output dcs_pkg::t_result            o_result
);
    import dcs_pkg::*;

    localparam int DA  = $clog2(MAX_NODES);
    localparam int EA  = $clog2(MAX_EDGES);
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NODE_W + WEIGHT_BITS;

    function automatic logic [DA-1:0] f_addr(input logic [NODE_W-1:0] node);
        logic [DA+NODE_W-1:0] w;
        w = {{DA{1'b0}}, node - NODE_W'(1)};
        return w[DA-1:0];
    endfunction

    t_state                    r_state, n_state;
    logic [NODE_W-1:0]         r_node_count, n_node_count;
    logic [ETW-1:0]            r_edge_total, n_edge_total;
    logic                      r_solved, n_solved;
    logic                      r_infeas, n_infeas;
    logic [MAX_NODES-1:0]      r_flags, n_flags;
    logic [NODE_W-1:0]         r_i, n_i;
    logic [ETW-1:0]            r_k, n_k;
    logic [NODE_W-1:0]         r_cur, n_cur;
    logic [HOP_W-1:0]          r_hops, n_hops;
    logic signed [DIST_W-1:0]  r_cur_dist, n_cur_dist;
    logic [NODE_W-1:0]         r_to, n_to;
    logic [WEIGHT_BITS-1:0]    r_w, n_w;
    logic                      r_valid, n_valid;
    t_result                   r_result, n_result;

    logic [NODE_W-1:0]         eff_n;
    logic                      accept;
    logic [BOUND_W+WEIGHT_BITS-1:0] bound_wide;

    logic                      e_we, e_re;
    logic [EA-1:0]             e_waddr, e_raddr;
    logic [EW-1:0]             e_wdata, e_rdata;
    logic [NODE_W-1:0]         e_to, e_from;
    logic [WEIGHT_BITS-1:0]    e_w;

    logic                      d_we, d_re;
    logic [DA-1:0]             d_waddr, d_raddr;
    logic [DIST_W-1:0]         d_wdata, d_rdata_raw;
    logic signed [DIST_W-1:0]  d_rdata;

    logic                      q_clear, q_push, q_pop, q_empty, q_full;
    t_qent                     q_push_data, q_pop_data;

    logic                      edge_hit, last_edge, hop_over, u_ok, store_full;
    logic signed [DIST_W-1:0]  cand, w_ext;

    always_comb begin
        if (r_node_count == '0) begin
            eff_n = NODE_W'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            eff_n = NODE_W'(MAX_NODES);
        end else begin
            eff_n = r_node_count;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign bound_wide = {{WEIGHT_BITS{1'b0}}, i_cmd.bound};
    assign store_full = (r_edge_total == ETW'(MAX_EDGES));

    assign {e_to, e_from, e_w} = e_rdata;
    assign d_rdata = $signed(d_rdata_raw);

    assign edge_hit  = (e_from == r_cur) && (e_to != '0) && (e_to <= eff_n);
    assign last_edge = ((r_k + ETW'(1)) == r_edge_total);
    assign hop_over  = (q_pop_data.hops > {1'b0, eff_n});
    assign u_ok      = (i_cmd.first_node != '0) && (i_cmd.first_node <= eff_n);
    assign w_ext     = {{(DIST_W-WEIGHT_BITS){r_w[WEIGHT_BITS-1]}}, r_w};
    assign cand      = r_cur_dist + w_ext;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd.func == FUNC_SOLVE) begin
                    n_state = S_INIT;
                end else if (accept && i_cmd.func == FUNC_READ && r_solved && !r_infeas
                             && u_ok) begin
                    n_state = S_RDW;
                end
            end
            S_RDW:   n_state = S_IDLE;
            S_INIT:  n_state = (r_i == eff_n) ? S_POP : S_INIT;
            S_POP:   n_state = q_empty ? S_IDLE : S_POPW;
            S_POPW:  n_state = hop_over ? S_IDLE : S_CURW;
            S_CURW:  n_state = (r_edge_total == '0) ? S_POP : S_EREAD;
            S_EREAD: n_state = S_EWAIT;
            S_EWAIT: begin
                if (edge_hit) begin
                    n_state = S_RELAX;
                end else begin
                    n_state = last_edge ? S_POP : S_EREAD;
                end
            end
            S_RELAX: n_state = last_edge ? S_POP : S_EREAD;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_node_count = r_node_count;
        n_edge_total = r_edge_total;
        n_solved     = r_solved;
        n_infeas     = r_infeas;
        n_flags      = r_flags;
        n_i          = r_i;
        n_k          = r_k;
        n_cur        = r_cur;
        n_hops       = r_hops;
        n_cur_dist   = r_cur_dist;
        n_to         = r_to;
        n_w          = r_w;
        n_valid      = 1'b0;
        n_result     = '0;
        e_we         = 1'b0;
        e_waddr      = r_edge_total[EA-1:0];
        e_wdata      = {i_cmd.first_node, i_cmd.second_node, bound_wide[WEIGHT_BITS-1:0]};
        e_re         = 1'b0;
        e_raddr      = r_k[EA-1:0];
        d_we         = 1'b0;
        d_waddr      = f_addr(r_i);
        d_wdata      = '0;
        d_re         = 1'b0;
        d_raddr      = f_addr(i_cmd.first_node);
        q_clear      = 1'b0;
        q_push       = 1'b0;
        q_push_data  = '{node: r_i, hops: HOP_W'(1)};
        q_pop        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.func)
                        FUNC_ADD: begin
                            n_valid = 1'b1;
                            if (store_full) begin
                                n_result.status = STAT_FULL;
                            end else begin
                                e_we         = 1'b1;
                                n_edge_total = r_edge_total + ETW'(1);
                                n_solved     = 1'b0;
                                n_infeas     = 1'b0;
                            end
                        end
                        FUNC_SOLVE: begin
                            n_i     = NODE_W'(1);
                            n_flags = '0;
                            q_clear = 1'b1;
                        end
                        FUNC_READ: begin
                            if (!r_solved) begin
                                n_valid         = 1'b1;
                                n_result.status = STAT_NOTSOLVED;
                            end else if (r_infeas) begin
                                n_valid         = 1'b1;
                                n_result.status = STAT_INFEAS;
                            end else if (u_ok) begin
                                d_re = 1'b1;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_valid      = 1'b1;
                            n_edge_total = '0;
                            n_solved     = 1'b0;
                            n_infeas     = 1'b0;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
                if (i_cfg_we) begin
                    n_node_count = i_cfg_data;
                    n_solved     = 1'b0;
                    n_infeas     = 1'b0;
                end
            end
            S_RDW: begin
                n_valid = 1'b1;
                if (d_rdata < VAL_MIN) begin
                    n_result.node_value = VAL_MIN[VALUE_W-1:0];
                end else if (d_rdata > VAL_MAX) begin
                    n_result.node_value = VAL_MAX[VALUE_W-1:0];
                end else begin
                    n_result.node_value = d_rdata[VALUE_W-1:0];
                end
            end
            S_INIT: begin
                d_we                  = 1'b1;
                q_push                = 1'b1;
                n_flags[f_addr(r_i)]  = 1'b1;
                n_i                   = r_i + NODE_W'(1);
            end
            S_POP: begin
                if (q_empty) begin
                    n_valid  = 1'b1;
                    n_solved = 1'b1;
                    n_infeas = 1'b0;
                end else begin
                    q_pop = 1'b1;
                end
            end
            S_POPW: begin
                n_cur                          = q_pop_data.node;
                n_hops                         = q_pop_data.hops;
                n_flags[f_addr(q_pop_data.node)] = 1'b0;
                if (hop_over) begin
                    n_valid         = 1'b1;
                    n_result.status = STAT_INFEAS;
                    n_solved        = 1'b1;
                    n_infeas        = 1'b1;
                end else begin
                    d_re    = 1'b1;
                    d_raddr = f_addr(q_pop_data.node);
                end
            end
            S_CURW: begin
                n_cur_dist = d_rdata;
                n_k        = '0;
            end
            S_EREAD: begin
                e_re = 1'b1;
            end
            S_EWAIT: begin
                n_to = e_to;
                n_w  = e_w;
                if (edge_hit) begin
                    d_re    = 1'b1;
                    d_raddr = f_addr(e_to);
                end else begin
                    n_k = r_k + ETW'(1);
                end
            end
            S_RELAX: begin
                n_k = r_k + ETW'(1);
                if (d_rdata > cand) begin
                    d_we    = 1'b1;
                    d_waddr = f_addr(r_to);
                    d_wdata = cand;
                    if (r_to == r_cur) begin
                        n_cur_dist = cand;
                    end
                    if (!r_flags[f_addr(r_to)] && !q_full) begin
                        q_push                = 1'b1;
                        q_push_data           = '{node: r_to, hops: r_hops + HOP_W'(1)};
                        n_flags[f_addr(r_to)] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RST;
            r_edge_total <= '0;
            r_solved     <= 1'b0;
            r_infeas     <= 1'b0;
            r_flags      <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_edge_total <= n_edge_total;
            r_solved     <= n_solved;
            r_infeas     <= n_infeas;
            r_flags      <= n_flags;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_hops     <= n_hops;
        r_cur_dist <= n_cur_dist;
        r_to       <= n_to;
        r_w        <= n_w;
        r_result   <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    dcs_ram #(
        .DEPTH(MAX_EDGES),
        .WIDTH(EW)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    dcs_ram #(
        .DEPTH(MAX_NODES),
        .WIDTH(DIST_W)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata_raw)
    );

    dcs_queue #(
        .MAX_NODES(MAX_NODES)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (q_clear),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

endmodule

/* sv/dcs_checker.sv */
// port level checks for the difference constraint solver, bound to the top level
// depends on dcs_pkg and difference_constraint_solver_assert.svh
`include "difference_constraint_solver_assert.svh"

module dcs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dcs_pkg::t_cmd    i_cmd,
    input logic             o_valid,
    input dcs_pkg::t_result o_result
);
    import dcs_pkg::*;

    `DCS_ASSERT_NXT(a_add_resp, i_clk, i_rst_n, start && !busy && i_cmd.func == FUNC_ADD, o_valid, "add gave no result")
    `DCS_ASSERT_NXT(a_clr_resp, i_clk, i_rst_n, start && !busy && i_cmd.func == FUNC_CLEAR, o_valid && o_result.status == STAT_OK, "clear gave no ok result")
    `DCS_ASSERT_IMP(a_val_nonpos, i_clk, i_rst_n, o_valid, o_result.node_value <= 0, "positive node value")
    `DCS_ASSERT_IMP(a_val_ok, i_clk, i_rst_n, o_valid && o_result.node_value != 0, o_result.status == STAT_OK, "value with bad status")

endmodule

bind difference_constraint_solver dcs_checker u_dcs_checker (.*);
